// ===== rtl/core/cru_pkg.sv =====
// ----------------------------------------------------------------------------
// cru_pkg
// Shared types and constants of the chroma row upsampler: payload words,
// the job word that travels from the front to the back, and mode codes.
// ----------------------------------------------------------------------------
package cru_pkg;

  // mode register codes; the unused code behaves as the separable mode
  localparam logic [1:0] MODE_VERT  = 2'd0;
  localparam logic [1:0] MODE_HORZ  = 2'd1;
  localparam logic [1:0] MODE_SEP   = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_SEP;

  // number of job entries between front and back
  localparam int QUEUE_DEPTH = 4;

  // rounding terms of the 3:1 filter
  localparam logic [9:0]  RND_QUARTER   = 10'd2;
  localparam logic [12:0] RND_SIXTEENTH = 13'd8;

  typedef struct packed {
    logic [7:0] near_sample;
    logic [7:0] far_sample;
    logic       row_end;
  } cru_in_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       run_last;
    logic       row_last;
  } cru_out_t;

  // one classified input: up to three bytes, index of the last one
  typedef struct packed {
    logic [7:0] pix0;
    logic [7:0] pix1;
    logic [7:0] pix2;
    logic [1:0] last_idx;
    logic       row_end;
  } cru_job_t;

  // queue head as seen by the back part
  typedef struct packed {
    logic     valid;
    cru_job_t job;
  } cru_head_t;

endpackage

// ===== rtl/core/chroma_row_upsampler.sv =====
// ----------------------------------------------------------------------------
// chroma_row_upsampler
// JPEG chroma upsampler with the 3:1 triangle filter: vertical blend,
// horizontal doubling or separable two-by-two doubling of one chroma row.
// ----------------------------------------------------------------------------
// Each input word carries one chroma column (near row sample, far row sample,
// row end mark) and yields one to three output bytes in row order; run_last
// marks the last byte of each input word and row_last the final byte of the
// row. The front takes a word whenever its job queue has room and works out
// all bytes of that word at once; the back drains the queue through a single
// output register at one byte per cycle while out_ready is high. The output
// byte rate thus sets the pace: one input word per cycle in vertical mode,
// fewer in the doubling modes, where a word yields up to two bytes, or up to
// three when it closes a row. An accepted word is written into the job queue
// and its first byte then loaded into the output register. The mode register
// is written through cfg_valid/cfg_data (always ready); the user must write
// it only while the block is idle, which the block does not enforce. Writes
// do not reset the row state. Code 3 acts as the separable mode.
// ----------------------------------------------------------------------------
module chroma_row_upsampler #(
  parameter int QueueDepth = cru_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  cru_pkg::cru_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cru_pkg::cru_out_t out_data
);
  import cru_pkg::*;

  logic      push;
  cru_job_t  push_job;
  logic      queue_full;
  logic      pop;
  cru_head_t head;

  // register writes complete at once
  assign cfg_ready = 1'b1;

  // front: classify each word into a job of output bytes
  cru_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // hold jobs so that input and output can stall on their own
  cru_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .head     (head)
  );

  // back: issue job bytes one per cycle while out_ready allows
  cru_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a row only closes on the last byte of a word
  a_row_last_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.row_last |-> out_data.run_last)
    else $error("row_last without run_last");

  // a full queue holds off input
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !in_ready)
    else $error("input taken while the queue is full");

endmodule

// ===== rtl/core/cru_front.sv =====
// ----------------------------------------------------------------------------
// cru_front
// Accept words, hold the mode register and the row state, and turn each
// word into a job of one to three output bytes.
// ----------------------------------------------------------------------------
module cru_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  cru_pkg::cru_in_t in_data,
  input  logic             queue_full,
  output logic             push,
  output cru_pkg::cru_job_t push_job
);
  import cru_pkg::*;

  logic [1:0]  mode;
  logic [9:0]  previous_value;
  logic        row_start;
  logic [9:0]  previous_value_next;

  logic [7:0]  n;
  logic [7:0]  p8;
  logic [9:0]  t;
  logic [9:0]  t_rnd;
  logic [7:0]  rim_pix;
  logic [9:0]  h_lead;
  logic [9:0]  h_trail;
  logic [12:0] s_lead;
  logic [12:0] s_trail;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  assign n       = in_data.near_sample;
  assign p8      = previous_value[7:0];
  assign t       = {2'b00, n} + {1'b0, n, 1'b0} + {2'b00, in_data.far_sample};
  assign t_rnd   = t + RND_QUARTER;
  assign rim_pix = t_rnd[9:2];
  assign h_lead  = {2'b00, p8} + {1'b0, p8, 1'b0} + {2'b00, n} + RND_QUARTER;
  assign h_trail = {2'b00, n} + {1'b0, n, 1'b0} + {2'b00, p8} + RND_QUARTER;
  assign s_lead  = {3'b000, previous_value} + {2'b00, previous_value, 1'b0}
                 + {3'b000, t} + RND_SIXTEENTH;
  assign s_trail = {3'b000, t} + {2'b00, t, 1'b0}
                 + {3'b000, previous_value} + RND_SIXTEENTH;

  always_comb begin
    push_job         = '0;
    push_job.row_end = in_data.row_end;
    previous_value_next = t;
    case (mode)
      MODE_VERT: begin
        push_job.pix0     = rim_pix;
        push_job.last_idx = 2'd0;
      end
      MODE_HORZ: begin
        previous_value_next = {2'b00, n};
        if (row_start) begin
          push_job.pix0     = n;
          push_job.pix1     = n;
          push_job.last_idx = in_data.row_end ? 2'd1 : 2'd0;
        end else if (in_data.row_end) begin
          // uneven weighting: the leading blend repeats, then copy the edge
          push_job.pix0     = h_lead[9:2];
          push_job.pix1     = h_lead[9:2];
          push_job.pix2     = n;
          push_job.last_idx = 2'd2;
        end else begin
          push_job.pix0     = h_lead[9:2];
          push_job.pix1     = h_trail[9:2];
          push_job.last_idx = 2'd1;
        end
      end
      default: begin
        if (row_start) begin
          push_job.pix0     = rim_pix;
          push_job.pix1     = rim_pix;
          push_job.last_idx = in_data.row_end ? 2'd1 : 2'd0;
        end else begin
          push_job.pix0     = s_lead[11:4];
          push_job.pix1     = s_trail[11:4];
          push_job.pix2     = rim_pix;
          push_job.last_idx = in_data.row_end ? 2'd2 : 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_RESET;
      previous_value <= '0;
      row_start      <= 1'b1;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data;
      end
      if (push) begin
        previous_value <= previous_value_next;
        row_start      <= in_data.row_end;
      end
    end
  end

  // a row's first word never yields three bytes
  a_first_short: assert property (@(posedge clk) disable iff (rst)
    push && row_start |-> push_job.last_idx != 2'd2)
    else $error("row start job with three bytes");

  // vertical mode always yields exactly one byte
  a_vert_single: assert property (@(posedge clk) disable iff (rst)
    push && mode == MODE_VERT |-> push_job.last_idx == 2'd0)
    else $error("vertical job with more than one byte");

endmodule

// ===== rtl/core/cru_queue.sv =====
// ----------------------------------------------------------------------------
// cru_queue
// Short job queue between the front and the back part.
// ----------------------------------------------------------------------------
module cru_queue #(
  parameter int Depth = cru_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cru_pkg::cru_job_t  push_job,
  output logic               full,
  input  logic               pop,
  output cru_pkg::cru_head_t head
);
  import cru_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cru_job_t        entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntFull);
  assign head.valid = (count != '0);
  assign head.job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != CntFull)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue underflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("empty queue with unequal pointers");

endmodule

// ===== rtl/core/cru_back.sv =====
// ----------------------------------------------------------------------------
// cru_back
// Walk the head job one byte per cycle, while out_ready allows, into the
// output register; drop the job once its last byte is loaded.
// ----------------------------------------------------------------------------
module cru_back (
  input  logic               clk,
  input  logic               rst,
  input  cru_pkg::cru_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output cru_pkg::cru_out_t  out_data
);
  import cru_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_last;
  logic [7:0] sel_pix;

  assign load    = head.valid && (!out_valid || out_ready);
  assign at_last = (idx == head.job.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    case (idx)
      2'd0:    sel_pix = head.job.pix0;
      2'd1:    sel_pix = head.job.pix1;
      default: sel_pix = head.job.pix2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.pixel    <= sel_pix;
      out_data.run_last <= at_last;
      out_data.row_last <= at_last && head.job.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> idx <= head.job.last_idx)
    else $error("byte index past end of job");

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !head.valid |-> idx == 2'd0)
    else $error("byte index left open without a job");

endmodule
